>>> rtl/rsvt_pkg.sv
// Shared types, constants and helper functions of the ray slab volume test.
// Used by every module of the block; depends on nothing.
package rsvt_pkg;

   localparam int NUM_SLABS_DEF = 7;
   localparam logic [2:0] NO_PLANE = 3'd7;
   localparam int DIV_STEPS = 49;
   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam int QDEPTH = 2;

   // One slab after classification by the front part.
   typedef struct packed {
      logic signed [32:0] diff_near;
      logic signed [32:0] diff_far;
      logic [31:0]        slope_mag;
      logic               slope_neg;
      logic               slope_zero;
      logic               zero_miss;
      logic               first;
      logic               last;
      logic signed [31:0] start_near;
      logic signed [31:0] start_far;
   } slab_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } back_state_type;

   // Applies the sign to a quotient magnitude and clamps it to 32 bits.
   function automatic logic signed [31:0] sat_quot(input logic [48:0] mag, input logic neg);
      logic signed [31:0] res;
      if (!neg && mag > 49'h0_7FFF_FFFF) begin
         res = 32'sh7FFF_FFFF;
      end else if (neg && mag > 49'h0_8000_0000) begin
         res = 32'sh8000_0000;
      end else if (neg) begin
         res = -$signed(mag[31:0]);
      end else begin
         res = $signed(mag[31:0]);
      end
      return res;
   endfunction

endpackage

>>> rtl/rsvt_if.sv
// Handshake interfaces for the slab input channel and the result channel.
// Depends on nothing.
interface rsvt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] slab_near;
   logic signed [31:0] slab_far;
   logic signed [31:0] ray_offset;
   logic signed [31:0] ray_slope;
   logic               first_slab;
   logic               last_slab;
   logic signed [31:0] start_near;
   logic signed [31:0] start_far;

   modport source (output valid, slab_near, slab_far, ray_offset, ray_slope,
                   first_slab, last_slab, start_near, start_far, input ready);
   modport sink (input valid, slab_near, slab_far, ray_offset, ray_slope,
                 first_slab, last_slab, start_near, start_far, output ready);
endinterface

interface rsvt_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] t_near_out;
   logic signed [31:0] t_far_out;
   logic [2:0]         entry_plane;

   modport source (output valid, hit, t_near_out, t_far_out, entry_plane, input ready);
   modport sink (input valid, hit, t_near_out, t_far_out, entry_plane, output ready);
endinterface

>>> rtl/ray_slab_volume_test.sv
// Channel   | Direction | Carries
// req_ch    | in        | one slab, with start interval on the first slab
// rsp_ch    | out       | hit, near, far and entry plane after the last slab
//
// In the back part a slab with a non-zero slope is taken from the queue in ST_IDLE,
// ST_DIV runs the two bit-serial Q16.16 divisions side by side, and ST_DONE
// updates the running interval. Zero-slope and ignored slabs skip ST_DIV.
// The front takes items while the two-entry queue has room; a held result only
// stalls the back part on a last slab. Synchronous reset, no clearing pass.
// Top level: front, queue and back part of the ray slab volume test.
// Depends on rsvt_pkg, rsvt_if and the three part modules.
module ray_slab_volume_test
   import rsvt_pkg::*;
#(
   parameter int NUM_SLABS = NUM_SLABS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rsvt_req_if.sink   req_ch,
   rsvt_rsp_if.source rsp_ch
);

   q_status_type q_status;
   logic         push, pop;
   slab_type     push_data, pop_data;

   rsvt_front u_front (
      .req_ch    (req_ch),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   rsvt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   rsvt_back #(.NUM_SLABS(NUM_SLABS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

>>> rtl/rsvt_front.sv
// Front part: accepts slab items and classifies them for the back part.
// Depends on rsvt_pkg and the request interface.
module rsvt_front
   import rsvt_pkg::*;
(
   rsvt_req_if.sink    req_ch,
   input  q_status_type q_status,
   output logic        push,
   output slab_type    push_data
);

   logic signed [31:0] slope;

   assign slope = req_ch.ray_slope;
   assign req_ch.ready = !q_status.full;
   assign push = req_ch.valid && !q_status.full;

   always_comb begin
      push_data.diff_near  = 33'(req_ch.slab_near) - 33'(req_ch.ray_offset);
      push_data.diff_far   = 33'(req_ch.slab_far) - 33'(req_ch.ray_offset);
      push_data.slope_mag  = slope[31] ? 32'(-slope) : 32'(slope);
      push_data.slope_neg  = slope[31];
      push_data.slope_zero = (slope == 32'sd0);
      // A ray parallel to the slab misses when its offset lies outside the slab.
      push_data.zero_miss  = (req_ch.ray_offset < req_ch.slab_near) ||
                             (req_ch.ray_offset > req_ch.slab_far);
      push_data.first      = req_ch.first_slab;
      push_data.last       = req_ch.last_slab;
      push_data.start_near = req_ch.start_near;
      push_data.start_far  = req_ch.start_far;
   end

endmodule

>>> rtl/rsvt_queue.sv
// Short queue of classified slabs between the front and the back part.
// Depends on rsvt_pkg.
module rsvt_queue
   import rsvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  slab_type     push_data,
   input  logic         pop,
   output slab_type     pop_data,
   output q_status_type q_status
);

   localparam int PTR_W = $clog2(QDEPTH);

   slab_type entry_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;

   assign q_status.full  = (fill_ff == (PTR_W+1)'(QDEPTH));
   assign q_status.empty = (fill_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/rsvt_back.sv
// Back part: divides out the slab interval, updates the running interval and
// drives the result register. Depends on rsvt_pkg and the result interface.
module rsvt_back
   import rsvt_pkg::*;
#(
   parameter int NUM_SLABS = NUM_SLABS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  slab_type     pop_data,
   output logic         pop,
   rsvt_rsp_if.source   rsp_ch
);

   back_state_type     state_ff, state_in;
   slab_type           item_ff, item_in;
   logic               active_ff, active_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [32:0]        rem_n_ff, rem_n_in, rem_f_ff, rem_f_in;
   logic [48:0]        num_n_ff, num_n_in, num_f_ff, num_f_in;
   logic signed [31:0] run_near_ff, run_near_in, run_far_ff, run_far_in;
   logic [2:0]         plane_ff, plane_in, count_ff, count_in;
   logic               missed_ff, missed_in;
   logic               rsp_valid_ff, rsp_valid_in, hit_ff, hit_in;
   logic signed [31:0] t_near_ff, t_near_in, t_far_ff, t_far_in;
   logic [2:0]         entry_ff, entry_in;

   logic               rsp_free, go;
   logic [81:0]        step_n, step_f;
   logic [32:0]        mag_n, mag_f;
   logic signed [31:0] q_n, q_f, tn, tf;

   // One restoring division step: returns the new remainder and quotient word.
   function automatic logic [81:0] div_step(input logic [32:0] rem, input logic [48:0] num,
                                            input logic [31:0] d);
      logic [32:0] sh;
      logic        ge;
      sh = {rem[31:0], num[48]};
      ge = (sh >= {1'b0, d});
      return {ge ? sh - {1'b0, d} : sh, {num[47:0], ge}};
   endfunction

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign pop = (state_ff == ST_IDLE) && !q_status.empty;
   assign go = (state_ff == ST_DONE) && (!item_ff.last || rsp_free);

   assign step_n = div_step(rem_n_ff, num_n_ff, item_ff.slope_mag);
   assign step_f = div_step(rem_f_ff, num_f_ff, item_ff.slope_mag);
   assign mag_n = pop_data.diff_near[32] ? 33'(-pop_data.diff_near) : 33'(pop_data.diff_near);
   assign mag_f = pop_data.diff_far[32] ? 33'(-pop_data.diff_far) : 33'(pop_data.diff_far);
   assign q_n = sat_quot(num_n_ff, item_ff.diff_near[32] ^ item_ff.slope_neg);
   assign q_f = sat_quot(num_f_ff, item_ff.diff_far[32] ^ item_ff.slope_neg);
   assign tn = item_ff.slope_neg ? q_f : q_n;
   assign tf = item_ff.slope_neg ? q_n : q_f;

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      active_in   = active_ff;
      cnt_in      = cnt_ff;
      rem_n_in    = rem_n_ff;
      rem_f_in    = rem_f_ff;
      num_n_in    = num_n_ff;
      num_f_in    = num_f_ff;
      run_near_in = run_near_ff;
      run_far_in  = run_far_ff;
      plane_in    = plane_ff;
      count_in    = count_ff;
      missed_in   = missed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      hit_in      = hit_ff;
      t_near_in   = t_near_ff;
      t_far_in    = t_far_ff;
      entry_in    = entry_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               item_in = pop_data;
               if (pop_data.first) begin
                  run_near_in = pop_data.start_near;
                  run_far_in  = pop_data.start_far;
                  plane_in    = NO_PLANE;
                  count_in    = '0;
                  missed_in   = 1'b0;
               end
               active_in = !missed_in && (count_in < 3'(NUM_SLABS));
               rem_n_in  = '0;
               rem_f_in  = '0;
               num_n_in  = {mag_n, 16'h0000};
               num_f_in  = {mag_f, 16'h0000};
               cnt_in    = CNT_W'(DIV_STEPS-1);
               state_in  = (active_in && !pop_data.slope_zero) ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            rem_n_in = step_n[81:49];
            num_n_in = step_n[48:0];
            rem_f_in = step_f[81:49];
            num_f_in = step_f[48:0];
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (go) begin
               if (active_ff) begin
                  count_in = count_ff + 1'b1;
                  if (item_ff.slope_zero) begin
                     missed_in = missed_ff || item_ff.zero_miss;
                  end else begin
                     if (tn > run_near_ff) begin
                        run_near_in = tn;
                        plane_in    = count_ff;
                     end
                     if (tf < run_far_ff) begin
                        run_far_in = tf;
                     end
                     missed_in = run_near_in > run_far_in;
                  end
               end
               if (item_ff.last) begin
                  rsp_valid_in = 1'b1;
                  hit_in       = !missed_in;
                  t_near_in    = run_near_in;
                  t_far_in     = run_far_in;
                  entry_in     = plane_in;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_near_ff  <= '0;
         run_far_ff   <= '0;
         plane_ff     <= NO_PLANE;
         count_ff     <= '0;
         missed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_near_ff  <= run_near_in;
         run_far_ff   <= run_far_in;
         plane_ff     <= plane_in;
         count_ff     <= count_in;
         missed_ff    <= missed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      active_ff <= active_in;
      cnt_ff    <= cnt_in;
      rem_n_ff  <= rem_n_in;
      rem_f_ff  <= rem_f_in;
      num_n_ff  <= num_n_in;
      num_f_ff  <= num_f_in;
      hit_ff    <= hit_in;
      t_near_ff <= t_near_in;
      t_far_ff  <= t_far_in;
      entry_ff  <= entry_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = hit_ff;
   assign rsp_ch.t_near_out  = t_near_ff;
   assign rsp_ch.t_far_out   = t_far_ff;
   assign rsp_ch.entry_plane = entry_ff;

endmodule

>>> rtl/rsvt_checker.sv
// Port-level checks of the ray slab volume test, bound to the top level.
// Depends on rsvt_pkg.
module rsvt_checker
   import rsvt_pkg::*;
#(
   parameter int NUM_SLABS = NUM_SLABS_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_hit,
   input logic signed [31:0] rsp_t_near,
   input logic [2:0]        rsp_entry
);

   // A waiting result must not vanish before it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_t_near) &&
      $stable(rsp_entry)) else $error("result changed while stalled");

   // Nothing is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result after reset");

   // An entry plane is either none or a slab that was counted.
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry == NO_PLANE) || (rsp_entry < 3'(NUM_SLABS)))
      else $error("entry plane out of range");

endmodule

bind ray_slab_volume_test rsvt_checker #(.NUM_SLABS(NUM_SLABS)) u_rsvt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_hit    (rsp_ch.hit),
   .rsp_t_near (rsp_ch.t_near_out),
   .rsp_entry  (rsp_ch.entry_plane)
);
